>>> rtl/refcounted_page_frame_allocator_defines.svh
// Assertion macros used by the allocator sequencer (rfa_ctrl)
`ifndef REFCOUNTED_PAGE_FRAME_ALLOCATOR_DEFINES_SVH
`define REFCOUNTED_PAGE_FRAME_ALLOCATOR_DEFINES_SVH

// expr must hold at every clock edge out of reset
`define RFA_ASSERT(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// expr must never hold at a clock edge out of reset
`define RFA_NEVER(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);

`endif

>>> rtl/rfa_pkg.sv
// Types and constants of the page-frame allocator
package rfa_pkg;

	localparam int CMD_W    = 3;
	localparam int PAGE_W   = 12;
	localparam int LEN_W    = 11;
	localparam int STAT_W   = 3;
	localparam int TOTAL_W  = 13;

	typedef enum logic [CMD_W-1:0] {
		CMD_ALLOC   = 3'd0,
		CMD_RESERVE = 3'd1,
		CMD_FREE    = 3'd2,
		CMD_FORCE   = 3'd3,
		CMD_INCREF  = 3'd4
	} cmd_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK     = 3'd0,
		STAT_NORUN  = 3'd1,
		STAT_RANGE  = 3'd2,
		STAT_DOUBLE = 3'd3,
		STAT_COUNT  = 3'd4
	} status_t;

	typedef enum logic [4:0] {
		S_CLEAR,
		S_IDLE,
		S_CNT_RD,
		S_CNT_EV,
		S_ALIGN,
		S_CHK_RD,
		S_CHK_EV,
		S_TAKE,
		S_HINT_RD,
		S_HINT_EV,
		S_REL_RD,
		S_REL_EV,
		S_MOD_RD,
		S_MOD_EV,
		S_INC_RD,
		S_INC_EV,
		S_REPLY
	} state_t;

	typedef struct packed {
		status_t              status;
		logic [PAGE_W-1:0]    page;
		logic [TOTAL_W-1:0]   free;
	} reply_t;

endpackage

>>> rtl/rfa_mem.sv
// Single-port frame memory with registered read data
module rfa_mem #(
	parameter int DEPTH = 4096,
	parameter int WIDTH = 17
) (
	input  logic                     clk,
	input  logic                     rd_en,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[addr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rdata <= mem[addr];
		end
	end

endmodule

>>> rtl/rfa_ctrl.sv
// Command sequencer: read-modify-write over the frame memory
`include "refcounted_page_frame_allocator_defines.svh"

module rfa_ctrl #(
	parameter int MAX_PAGES   = 4096,
	parameter int MAX_RUN     = 1024,
	parameter int COUNT_WIDTH = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [rfa_pkg::TOTAL_W-1:0]   total_pages,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [rfa_pkg::CMD_W-1:0]     command,
	input  logic [rfa_pkg::PAGE_W-1:0]    first_page,
	input  logic [rfa_pkg::LEN_W-1:0]     page_count,
	output logic                          reply_valid,
	input  logic                          reply_ready,
	output rfa_pkg::reply_t               reply
);

	localparam int AW = $clog2(MAX_PAGES);
	localparam int NW = (AW + 2 > 14) ? AW + 2 : 14;
	localparam int CW = COUNT_WIDTH;
	localparam int MW = CW + 1;
	localparam logic [CW-1:0] CNT_ONE = CW'(1);
	localparam logic [CW-1:0] CNT_MAX = {CW{1'b1}};

	rfa_pkg::state_t  state_q, state_d;
	rfa_pkg::cmd_t    op_q;
	rfa_pkg::status_t stat_q;
	logic [NW-1:0]    idx_q, base_q, end_q, cnt_q, hint_q, used_q;
	logic [rfa_pkg::PAGE_W-1:0] page_q;
	logic             zero_q, pend_q;

	logic             rd_en, wr_en;
	logic [AW-1:0]    mem_addr;
	logic [MW-1:0]    wdata, rdata;
	logic             rused;
	logic [CW-1:0]    rcnt;

	logic [NW-1:0]    tot, pn_x, cnt_x, run_end;
	logic             len_ok, last, accept, rel_frame, inc_bad;
	rfa_pkg::state_t  dec_state;
	rfa_pkg::status_t dec_stat;

	assign rused = rdata[CW];
	assign rcnt  = rdata[CW-1:0];
	assign tot   = (NW'(total_pages) > NW'(MAX_PAGES)) ? NW'(MAX_PAGES) : NW'(total_pages);
	assign pn_x  = NW'(first_page);
	assign cnt_x = NW'(page_count);
	assign run_end = pn_x + cnt_x;
	assign len_ok = (cnt_x != '0) && (cnt_x <= NW'(MAX_RUN));
	assign last   = (idx_q + NW'(1)) == end_q;
	assign accept = (state_q == rfa_pkg::S_IDLE) && !pend_q && in_valid;
	assign rel_frame = (op_q == rfa_pkg::CMD_FORCE) || (rcnt == CNT_ONE);
	assign inc_bad = !rused || (rcnt == '0) || (rcnt == CNT_MAX);

	rfa_mem #(
		.DEPTH(MAX_PAGES),
		.WIDTH(MW)
	) u_mem (
		.clk  (clk),
		.rd_en(rd_en),
		.wr_en(wr_en),
		.addr (mem_addr),
		.wdata(wdata),
		.rdata(rdata)
	);

	always_comb begin
		dec_state = rfa_pkg::S_REPLY;
		dec_stat  = rfa_pkg::STAT_RANGE;
		unique case (command)
			rfa_pkg::CMD_ALLOC: begin
				if (len_ok) begin
					dec_state = rfa_pkg::S_ALIGN;
					dec_stat  = rfa_pkg::STAT_OK;
				end
			end
			rfa_pkg::CMD_RESERVE: begin
				if (len_ok && pn_x < tot && run_end <= tot) begin
					dec_state = rfa_pkg::S_CHK_RD;
					dec_stat  = rfa_pkg::STAT_OK;
				end
			end
			rfa_pkg::CMD_FREE, rfa_pkg::CMD_FORCE: begin
				if (len_ok && pn_x < tot) begin
					dec_state = rfa_pkg::S_REL_RD;
					dec_stat  = rfa_pkg::STAT_OK;
				end
			end
			rfa_pkg::CMD_INCREF: begin
				if (pn_x < tot) begin
					dec_state = rfa_pkg::S_INC_RD;
					dec_stat  = rfa_pkg::STAT_OK;
				end
			end
			default: begin
				dec_state = rfa_pkg::S_REPLY;
			end
		endcase
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			rfa_pkg::S_CLEAR:   if (idx_q == NW'(MAX_PAGES - 1)) state_d = rfa_pkg::S_IDLE;
			rfa_pkg::S_IDLE: begin
				if (pend_q) begin
					state_d = rfa_pkg::S_CNT_RD;
				end else if (in_valid) begin
					state_d = dec_state;
				end
			end
			rfa_pkg::S_CNT_RD:  state_d = (idx_q >= tot) ? rfa_pkg::S_IDLE : rfa_pkg::S_CNT_EV;
			rfa_pkg::S_CNT_EV:  state_d = rfa_pkg::S_CNT_RD;
			rfa_pkg::S_ALIGN: begin
				if (base_q >= hint_q) begin
					state_d = (base_q + cnt_q > tot) ? rfa_pkg::S_HINT_RD : rfa_pkg::S_CHK_RD;
				end
			end
			rfa_pkg::S_CHK_RD:  state_d = rfa_pkg::S_CHK_EV;
			rfa_pkg::S_CHK_EV: begin
				if (rused) begin
					state_d = (op_q == rfa_pkg::CMD_ALLOC) ? rfa_pkg::S_ALIGN : rfa_pkg::S_REPLY;
				end else begin
					state_d = last ? rfa_pkg::S_TAKE : rfa_pkg::S_CHK_RD;
				end
			end
			rfa_pkg::S_TAKE: begin
				if (last) begin
					state_d = (op_q == rfa_pkg::CMD_ALLOC) ? rfa_pkg::S_HINT_RD : rfa_pkg::S_REPLY;
				end
			end
			rfa_pkg::S_HINT_RD: state_d = (hint_q >= tot) ? rfa_pkg::S_REPLY : rfa_pkg::S_HINT_EV;
			rfa_pkg::S_HINT_EV: state_d = rused ? rfa_pkg::S_HINT_RD : rfa_pkg::S_REPLY;
			rfa_pkg::S_REL_RD:  state_d = rfa_pkg::S_REL_EV;
			rfa_pkg::S_REL_EV: begin
				if (!rused) begin
					state_d = rfa_pkg::S_REPLY;
				end else if (last) begin
					state_d = (zero_q || rcnt == '0) ? rfa_pkg::S_REPLY : rfa_pkg::S_MOD_RD;
				end else begin
					state_d = rfa_pkg::S_REL_RD;
				end
			end
			rfa_pkg::S_MOD_RD:  state_d = rfa_pkg::S_MOD_EV;
			rfa_pkg::S_MOD_EV:  state_d = last ? rfa_pkg::S_REPLY : rfa_pkg::S_MOD_RD;
			rfa_pkg::S_INC_RD:  state_d = rfa_pkg::S_INC_EV;
			rfa_pkg::S_INC_EV:  state_d = rfa_pkg::S_REPLY;
			rfa_pkg::S_REPLY:   if (reply_ready) state_d = rfa_pkg::S_IDLE;
			default:            state_d = rfa_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		in_stall    = !((state_q == rfa_pkg::S_IDLE) && !pend_q);
		reply_valid = (state_q == rfa_pkg::S_REPLY);
		reply.status = stat_q;
		reply.page   = page_q;
		reply.free   = rfa_pkg::TOTAL_W'(tot - used_q);
		rd_en    = 1'b0;
		wr_en    = 1'b0;
		mem_addr = idx_q[AW-1:0];
		wdata    = '0;
		unique case (state_q)
			rfa_pkg::S_CLEAR:   wr_en = 1'b1;
			rfa_pkg::S_CNT_RD:  rd_en = (idx_q < tot);
			rfa_pkg::S_CHK_RD,
			rfa_pkg::S_REL_RD,
			rfa_pkg::S_MOD_RD,
			rfa_pkg::S_INC_RD:  rd_en = 1'b1;
			rfa_pkg::S_HINT_RD: begin
				rd_en    = (hint_q < tot);
				mem_addr = hint_q[AW-1:0];
			end
			rfa_pkg::S_TAKE: begin
				wr_en = 1'b1;
				wdata = {1'b1, CNT_ONE};
			end
			rfa_pkg::S_MOD_EV: begin
				wr_en = 1'b1;
				wdata = rel_frame ? '0 : {1'b1, rcnt - CNT_ONE};
			end
			rfa_pkg::S_INC_EV: begin
				wr_en = !inc_bad;
				wdata = {1'b1, rcnt + CNT_ONE};
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rfa_pkg::S_CLEAR;
			idx_q   <= '0;
			hint_q  <= '0;
			used_q  <= '0;
			pend_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				pend_q <= 1'b1;
			end else if (state_q == rfa_pkg::S_IDLE && pend_q) begin
				pend_q <= 1'b0;
			end
			unique case (state_q)
				rfa_pkg::S_CLEAR: idx_q <= idx_q + NW'(1);
				rfa_pkg::S_IDLE: begin
					if (pend_q) begin
						idx_q  <= '0;
						used_q <= '0;
					end else if (accept) begin
						idx_q <= pn_x;
					end
				end
				rfa_pkg::S_CNT_EV: begin
					used_q <= used_q + NW'(rused);
					idx_q  <= idx_q + NW'(1);
				end
				rfa_pkg::S_ALIGN: begin
					if (base_q >= hint_q) begin
						idx_q <= base_q;
					end
				end
				rfa_pkg::S_CHK_EV: begin
					if (!rused) begin
						idx_q <= last ? base_q : idx_q + NW'(1);
					end
				end
				rfa_pkg::S_TAKE: begin
					used_q <= used_q + NW'(1);
					idx_q  <= idx_q + NW'(1);
				end
				rfa_pkg::S_HINT_EV: begin
					if (rused) begin
						hint_q <= hint_q + NW'(1);
					end
				end
				rfa_pkg::S_REL_EV: begin
					if (rused) begin
						idx_q <= last ? base_q : idx_q + NW'(1);
					end
				end
				rfa_pkg::S_MOD_EV: begin
					idx_q <= idx_q + NW'(1);
					if (rel_frame) begin
						used_q <= used_q - NW'(1);
						if (idx_q < hint_q) begin
							hint_q <= idx_q;
						end
					end
				end
				default: begin
					idx_q <= idx_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			rfa_pkg::S_IDLE: begin
				if (accept) begin
					op_q   <= rfa_pkg::cmd_t'(command);
					stat_q <= dec_stat;
					cnt_q  <= cnt_x;
					base_q <= (command == rfa_pkg::CMD_ALLOC) ? '0 : pn_x;
					end_q  <= (run_end > tot) ? tot : run_end;
					zero_q <= 1'b0;
					page_q <= '0;
				end
			end
			rfa_pkg::S_ALIGN: begin
				if (base_q < hint_q) begin
					base_q <= base_q + cnt_q;
				end else if (base_q + cnt_q > tot) begin
					stat_q <= rfa_pkg::STAT_NORUN;
				end else begin
					end_q <= base_q + cnt_q;
				end
			end
			rfa_pkg::S_CHK_EV: begin
				if (rused) begin
					if (op_q == rfa_pkg::CMD_ALLOC) begin
						base_q <= base_q + cnt_q;
					end else begin
						stat_q <= rfa_pkg::STAT_NORUN;
					end
				end
			end
			rfa_pkg::S_TAKE: begin
				if (last && op_q == rfa_pkg::CMD_ALLOC) begin
					page_q <= base_q[rfa_pkg::PAGE_W-1:0];
				end
			end
			rfa_pkg::S_REL_EV: begin
				if (!rused) begin
					stat_q <= rfa_pkg::STAT_DOUBLE;
				end else if (last && (zero_q || rcnt == '0)) begin
					stat_q <= rfa_pkg::STAT_COUNT;
				end else begin
					zero_q <= zero_q || (rcnt == '0);
				end
			end
			rfa_pkg::S_INC_EV: begin
				if (inc_bad) begin
					stat_q <= rfa_pkg::STAT_COUNT;
				end
			end
			default: begin
				zero_q <= zero_q;
			end
		endcase
	end

	`RFA_NEVER(a_port_conflict, rd_en && wr_en, "read and write on the single port")
	`RFA_ASSERT(a_used_bound, used_q <= NW'(MAX_PAGES), "used count beyond map size")
	`RFA_ASSERT(a_take_in_run, state_q != rfa_pkg::S_TAKE || idx_q < end_q, "take past run end")
	`RFA_NEVER(a_accept_busy, !in_stall && state_q != rfa_pkg::S_IDLE, "request taken while busy")

endmodule

>>> rtl/refcounted_page_frame_allocator.sv
// Top level of the page-frame allocator: config register, result register, sequencer
//
// channel | handshake            | payload
// in      | in_valid / in_stall  | command, first_page, page_count
// out     | out_valid / out_stall| status, result_page, free_pages
// cfg     | cfg_valid / cfg_ready| total_pages
//
// A frame access is a read state and an evaluate state. A request accesses each frame
// checked, writes each frame taken, accesses each released frame twice (check, then write),
// updates a frame counted up and, for alloc, steps alignment and then walks the hint, plus
// accept and reply states. Reset starts a clearing pass of all MAX_PAGES frames before the
// first request; a total_pages write recounts used frames below min(total_pages, MAX_PAGES).
// A waiting result does not block the next request; only a second result waits.
module refcounted_page_frame_allocator #(
	parameter int MAX_PAGES   = 4096,
	parameter int MAX_RUN     = 1024,
	parameter int COUNT_WIDTH = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [rfa_pkg::TOTAL_W-1:0]  total_pages,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [rfa_pkg::CMD_W-1:0]    command,
	input  logic [rfa_pkg::PAGE_W-1:0]   first_page,
	input  logic [rfa_pkg::LEN_W-1:0]    page_count,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [rfa_pkg::STAT_W-1:0]   status,
	output logic [rfa_pkg::PAGE_W-1:0]   result_page,
	output logic [rfa_pkg::TOTAL_W-1:0]  free_pages
);

	logic [rfa_pkg::TOTAL_W-1:0] total_q;
	logic                        cfg_we;
	logic                        reply_valid, reply_ready;
	rfa_pkg::reply_t             reply, out_q;
	logic                        out_valid_q;

	assign cfg_ready   = 1'b1;
	assign cfg_we      = cfg_valid;
	assign reply_ready = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= rfa_pkg::TOTAL_W'(4096);
		end else if (cfg_we) begin
			total_q <= total_pages;
		end
	end

	rfa_ctrl #(
		.MAX_PAGES  (MAX_PAGES),
		.MAX_RUN    (MAX_RUN),
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.total_pages(total_q),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.command    (command),
		.first_page (first_page),
		.page_count (page_count),
		.reply_valid(reply_valid),
		.reply_ready(reply_ready),
		.reply      (reply)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (reply_ready) begin
			out_valid_q <= reply_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (reply_ready && reply_valid) begin
			out_q <= reply;
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = out_q.status;
	assign result_page = out_q.page;
	assign free_pages  = out_q.free;

endmodule
